>>> rtl/spq_pkg.sv
package spq_pkg;

   localparam int DEF_CAPACITY   = 16;
   localparam int DEF_DATA_WIDTH = 32;
   localparam int VALUE_WIDTH    = 32;
   localparam int COUNT_WIDTH    = 5;
   localparam int EXT_WIDTH      = 64;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_PEEK   = 2'd2,
      OP_NOP    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      opcode_type                     opcode;
      logic signed [VALUE_WIDTH-1:0]  value_in;
   } spq_req_type;

   typedef struct packed {
      status_type                     status;
      logic signed [VALUE_WIDTH-1:0]  value_out;
      logic [COUNT_WIDTH-1:0]         count;
   } spq_rsp_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic ins;
      logic rem;
   } spq_cmd_type;

endpackage

>>> rtl/spq_cell.sv
module spq_cell
   import spq_pkg::*;
#(
   parameter int DATA_WIDTH = DEF_DATA_WIDTH
)(
   input  logic                  clock,
   input  spq_cmd_type           cmd,
   input  logic [DATA_WIDTH-1:0] ins_value,
   input  logic                  occupied,
   input  logic                  left_take,
   input  logic [DATA_WIDTH-1:0] left_value,
   input  logic [DATA_WIDTH-1:0] right_value,
   output logic                  take,
   output logic [DATA_WIDTH-1:0] value
);

   logic [DATA_WIDTH-1:0] value_ff;
   logic [DATA_WIDTH-1:0] value_in;

   // the new value belongs here or further left when it is not below this entry or this cell is empty
   assign take  = !occupied || ($signed(ins_value) >= $signed(value_ff));
   assign value = value_ff;

   always_comb begin
      value_in = value_ff;
      if (cmd.ins) begin
         if (left_take) begin
            value_in = left_value;
         end else if (take) begin
            value_in = ins_value;
         end
      end else if (cmd.rem) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

>>> rtl/spq_rsp_buf.sv
module spq_rsp_buf
   import spq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  spq_rsp_type push_data,
   output logic        full,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output spq_rsp_type rsp_payload
);

   logic [1:0]  occ_ff, occ_in;
   spq_rsp_type head_ff, head_in;
   spq_rsp_type skid_ff, skid_in;
   logic        pop;

   assign pop         = rsp_valid && rsp_ready;
   assign full        = (occ_ff == 2'd2);
   assign rsp_valid   = (occ_ff != 2'd0);
   assign rsp_payload = head_ff;

   always_comb begin
      occ_in  = occ_ff;
      head_in = head_ff;
      skid_in = skid_ff;
      unique case ({push, pop})
         2'b10: begin
            if (occ_ff == 2'd0) begin
               head_in = push_data;
            end else begin
               skid_in = push_data;
            end
            occ_in = occ_ff + 2'd1;
         end
         2'b01: begin
            head_in = skid_ff;
            occ_in  = occ_ff - 2'd1;
         end
         2'b11: begin
            if (occ_ff == 2'd1) begin
               head_in = push_data;
            end else begin
               head_in = skid_ff;
               skid_in = push_data;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 2'd0;
      end else begin
         occ_ff <= occ_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule

>>> rtl/sorted_priority_queue_core.sv
// channel   direction   handshake              payload
// req_      in          req_valid / req_ready  spq_req_type (opcode, value_in)
// rsp_      out         rsp_valid / rsp_ready  spq_rsp_type (status, value_out, count)
//
// one transaction per cycle while req_ready is high; its response is registered in the response buffer on acceptance.
// the chain of cells compares every entry with the new value in the same cycle.
// a two-entry response buffer keeps accepting while fewer than two responses wait.
// reset clears the count and the response buffer; stored entries need no clearing.
// req_ready falls only while both response slots are occupied.
module sorted_priority_queue_core
   import spq_pkg::*;
#(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int DATA_WIDTH = DEF_DATA_WIDTH
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  spq_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output spq_rsp_type rsp_payload
);

   localparam int CW = $clog2(CAPACITY + 1);

   logic [CW-1:0]                 count_ff, count_in;
   logic                          req_fire;
   logic                          is_full, is_empty;
   logic                          buf_full;
   spq_cmd_type                   cmd;
   spq_rsp_type                   rsp_data;
   logic signed [EXT_WIDTH-1:0]   ext_in;
   logic signed [EXT_WIDTH-1:0]   ext_head;
   logic [DATA_WIDTH-1:0]         ins_value;
   logic [DATA_WIDTH-1:0]         cell_value [CAPACITY];
   logic                          cell_take  [CAPACITY];

   assign req_ready = !buf_full;
   assign req_fire  = req_valid && req_ready;
   assign is_full   = (count_ff == CW'(CAPACITY));
   assign is_empty  = (count_ff == '0);

   assign ext_in    = EXT_WIDTH'(req_payload.value_in);
   assign ins_value = ext_in[DATA_WIDTH-1:0];
   assign ext_head  = EXT_WIDTH'($signed(cell_value[0]));

   always_comb begin
      cmd                = '0;
      count_in           = count_ff;
      rsp_data.status    = ST_OK;
      rsp_data.value_out = '0;
      unique case (req_payload.opcode)
         OP_INSERT: begin
            if (is_full) begin
               rsp_data.status = ST_FULL;
            end else begin
               cmd.ins  = req_fire;
               count_in = count_ff + 1'b1;
            end
         end
         OP_REMOVE, OP_PEEK: begin
            if (is_empty) begin
               rsp_data.status = ST_EMPTY;
            end else begin
               rsp_data.value_out = ext_head[VALUE_WIDTH-1:0];
               if (req_payload.opcode == OP_REMOVE) begin
                  cmd.rem  = req_fire;
                  count_in = count_ff - 1'b1;
               end
            end
         end
         OP_NOP: begin
         end
         default: begin
         end
      endcase
      rsp_data.count = COUNT_WIDTH'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (req_fire) begin
         count_ff <= count_in;
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                  left_take;
      logic [DATA_WIDTH-1:0] left_value;
      logic [DATA_WIDTH-1:0] right_value;

      if (i == 0) begin : g_first
         assign left_take  = 1'b0;
         assign left_value = '0;
      end else begin : g_mid
         assign left_take  = cell_take[i-1];
         assign left_value = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_value = '0;
      end else begin : g_inner
         assign right_value = cell_value[i+1];
      end

      spq_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .ins_value   (ins_value),
         .occupied    (CW'(i) < count_ff),
         .left_take   (left_take),
         .left_value  (left_value),
         .right_value (right_value),
         .take        (cell_take[i]),
         .value       (cell_value[i])
      );
   end

   spq_rsp_buf u_rsp_buf (
      .clock       (clock),
      .reset       (reset),
      .push        (req_fire),
      .push_data   (rsp_data),
      .full        (buf_full),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("held count above capacity");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      cmd.ins |=> count_ff == CW'($past(count_ff) + 1'b1))
      else $error("insert did not advance the count");

   a_head_order: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CW'(2) |-> $signed(cell_value[0]) >= $signed(cell_value[1]))
      else $error("head entry below its neighbour");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == ST_FULL
         |-> rsp_payload.count == COUNT_WIDTH'(CAPACITY))
      else $error("full status with a count below capacity");

endmodule

>>> bench/tb_sorted_priority_queue_core.sv
`timescale 1ns / 100ps

module tb_sorted_priority_queue_core;
   import spq_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_ITEMS = 1600;
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      opcode_type              op;
      logic [VALUE_WIDTH-1:0]  value;
      logic                    typed;
      status_type              st;
      logic [VALUE_WIDTH-1:0]  val_exp;
      logic [COUNT_WIDTH-1:0]  cnt_exp;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   spq_req_type req_payload;
   logic        rsp_valid;
   logic        rsp_ready;
   spq_rsp_type rsp_payload;

   // predictor state: held values, largest first
   logic signed [VALUE_WIDTH-1:0] held_values [DEF_CAPACITY];
   int                            held_total;

   spq_rsp_type rsp_expected [$];
   int          mismatch_count = 0;
   int          idle_cycles;
   bit          calm = 1'b0;

   directed_row_type directed_rows [0:24] = '{
      '{OP_REMOVE, 32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000, 5'd0},
      '{OP_PEEK,   32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000, 5'd0},
      '{OP_NOP,    32'hffff_ffff, 1'b1, ST_OK,    32'h0000_0000, 5'd0},
      '{OP_INSERT, 32'h7fff_ffff, 1'b1, ST_OK,    32'h0000_0000, 5'd1},
      '{OP_INSERT, 32'h8000_0000, 1'b1, ST_OK,    32'h0000_0000, 5'd2},
      '{OP_PEEK,   32'h0000_0000, 1'b1, ST_OK,    32'h7fff_ffff, 5'd2},
      '{OP_REMOVE, 32'hffff_ffff, 1'b1, ST_OK,    32'h7fff_ffff, 5'd1},
      '{OP_REMOVE, 32'h0000_0000, 1'b1, ST_OK,    32'h8000_0000, 5'd0},
      // fill to capacity, ties and mixed signs included
      '{OP_INSERT, 32'hffff_ffff, 1'b0, ST_OK,    32'h0000_0000, 5'd0},
      '{OP_INSERT, 32'hffff_ffff, 1'b0, ST_OK,    32'h0000_0000, 5'd0},
      '{OP_INSERT, 32'h5555_5555, 1'b0, ST_OK,    32'h0000_0000, 5'd0},
      '{OP_INSERT, 32'haaaa_aaaa, 1'b0, ST_OK,    32'h0000_0000, 5'd0},
      '{OP_INSERT, 32'h7fff_ffff, 1'b0, ST_OK,    32'h0000_0000, 5'd0},
      '{OP_INSERT, 32'h8000_0000, 1'b0, ST_OK,    32'h0000_0000, 5'd0},
      '{OP_INSERT, 32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000, 5'd0},
      '{OP_INSERT, 32'h0000_0001, 1'b0, ST_OK,    32'h0000_0000, 5'd0},
      '{OP_INSERT, 32'h7fff_ffff, 1'b0, ST_OK,    32'h0000_0000, 5'd0},
      '{OP_INSERT, 32'h8000_0000, 1'b0, ST_OK,    32'h0000_0000, 5'd0},
      '{OP_INSERT, 32'h0000_0064, 1'b0, ST_OK,    32'h0000_0000, 5'd0},
      '{OP_INSERT, 32'hffff_ff9c, 1'b0, ST_OK,    32'h0000_0000, 5'd0},
      '{OP_INSERT, 32'h0000_ffff, 1'b0, ST_OK,    32'h0000_0000, 5'd0},
      '{OP_INSERT, 32'hffff_0000, 1'b0, ST_OK,    32'h0000_0000, 5'd0},
      '{OP_INSERT, 32'h0000_0007, 1'b0, ST_OK,    32'h0000_0000, 5'd0},
      '{OP_INSERT, 32'hffff_fff9, 1'b0, ST_OK,    32'h0000_0000, 5'd0},
      '{OP_INSERT, 32'h1234_5678, 1'b1, ST_FULL,  32'h0000_0000, 5'd16}
   };

   sorted_priority_queue_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic spq_rsp_type queue_apply(input opcode_type op,
                                               input logic signed [VALUE_WIDTH-1:0] v);
      spq_rsp_type r;
      int          pos;
      r.status    = ST_OK;
      r.value_out = '0;
      case (op)
         OP_INSERT: begin
            if (held_total >= DEF_CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               pos = 0;
               while (pos < held_total && v < held_values[pos]) pos++;
               for (int i = held_total; i > pos; i--) held_values[i] = held_values[i-1];
               held_values[pos] = v;
               held_total++;
            end
         end
         OP_REMOVE, OP_PEEK: begin
            if (held_total == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.value_out = held_values[0];
               if (op == OP_REMOVE) begin
                  for (int i = 1; i < held_total; i++) held_values[i-1] = held_values[i];
                  held_total--;
               end
            end
         end
         default: ;
      endcase
      r.count = held_total[COUNT_WIDTH-1:0];
      return r;
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0:       return 32'h7fff_ffff;
         1:       return 32'h8000_0000;
         2, 3:    return $urandom_range(0, 8) - 4;  // narrow range to force ties
         default: return $urandom;
      endcase
   endfunction

   task automatic send_transaction(input opcode_type op, input logic [VALUE_WIDTH-1:0] value,
                                   input logic typed, input spq_rsp_type typed_rsp);
      spq_rsp_type predicted;
      int          gap;
      int          r;
      predicted = queue_apply(op, value);
      rsp_expected.push_back(typed ? typed_rsp : predicted);
      r = $urandom_range(0, 99);
      if (calm || r < 60) gap = 0;
      else if (r < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 30);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{op, value};
      do @(posedge clock); while (!req_ready);
   endtask

   // result checking and receiver stalls
   int stall_left = 0;
   always @(posedge clock) begin
      spq_rsp_type exp_rsp;
      int          r;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_expected.size() == 0) begin
               $error("result with no transaction outstanding: %h", rsp_payload);
               mismatch_count++;
            end else begin
               exp_rsp = rsp_expected.pop_front();
               if (rsp_payload.status !== exp_rsp.status) begin
                  $error("status expected %0d actual %0d", exp_rsp.status, rsp_payload.status);
                  mismatch_count++;
               end
               if (rsp_payload.value_out !== exp_rsp.value_out) begin
                  $error("value_out expected %0d actual %0d",
                         exp_rsp.value_out, rsp_payload.value_out);
                  mismatch_count++;
               end
               if (rsp_payload.count !== exp_rsp.count) begin
                  $error("count expected %0d actual %0d", exp_rsp.count, rsp_payload.count);
                  mismatch_count++;
               end
            end
         end
         if (calm) begin
            rsp_ready  <= 1'b1;
            stall_left <= 0;
         end else if (stall_left > 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_left - 1;
         end else begin
            rsp_ready <= 1'b1;
            r = $urandom_range(0, 99);
            if (r < 15) stall_left <= $urandom_range(1, 3);
            else if (r < 17) stall_left <= $urandom_range(10, 40);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int         sent;
      int         phase_len;
      int         ins_pct;
      int         r;
      opcode_type op;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      rsp_ready   = 1'b0;
      held_total  = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[k]) begin
         send_transaction(directed_rows[k].op, directed_rows[k].value, directed_rows[k].typed,
                          '{directed_rows[k].st, directed_rows[k].val_exp,
                            directed_rows[k].cnt_exp});
      end

      // phases lean towards filling or draining, or stay balanced, so full and empty recur
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         r = $urandom_range(0, 2);
         ins_pct   = (r == 0) ? 85 : (r == 1) ? 15 : 50;
         phase_len = $urandom_range(10, 60);
         calm      = ($urandom_range(0, 4) == 0);
         repeat (phase_len) begin
            r = $urandom_range(0, 99);
            if (r < 3) op = OP_NOP;
            else if (r < 3 + (ins_pct * 97) / 100) op = OP_INSERT;
            else op = ($urandom_range(0, 2) == 0) ? OP_PEEK : OP_REMOVE;
            send_transaction(op, pick_value(), 1'b0, '0);
            sent++;
         end
      end
      req_valid <= 1'b0;
      calm      = 1'b0;

      while (rsp_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (rsp_expected.size() != 0) begin
         $error("%0d results never arrived", rsp_expected.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/spq_rsp_buf.sv
rtl/sorted_priority_queue_core.sv
bench/tb_sorted_priority_queue_core.sv
